// File: rtl/smac_pkg.sv
// ----------------------------------------------------------------------------
// smac_pkg
// shared constants, codes and controller/datapath interface types for the
// shadow memory access checker
// ----------------------------------------------------------------------------
package smac_pkg;

  // store geometry
  localparam int unsigned SHADOW_INDEX_BITS = 16;
  localparam int unsigned GRANULE_SHIFT     = 3;
  localparam int unsigned MAX_LENGTH        = 65536;
  localparam int unsigned STORE_DEPTH       = 1 << SHADOW_INDEX_BITS;

  // field widths
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned LEN_W      = 17;
  localparam int unsigned FILL_W     = 8;
  localparam int unsigned SHADOW_W   = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // granule index of a 33-bit byte address
  localparam int unsigned GIDX_W = ADDR_W + 1 - GRANULE_SHIFT;

  // clamped length, wide enough for the granule remainder too
  localparam int unsigned CLEN_RAW_W = $clog2(MAX_LENGTH + 1);
  localparam int unsigned CLEN_W     = (CLEN_RAW_W > GRANULE_SHIFT) ? CLEN_RAW_W
                                                                    : GRANULE_SHIFT + 1;

  // configuration reset values
  localparam logic        CHECK_ENABLE_RST = 1'b0;
  localparam logic [31:0] SHADOW_START_RST = 32'h0000_0000;
  localparam logic [31:0] SHADOW_END_RST   = 32'h0000_0000;
  localparam logic [31:0] IO_START_RST     = 32'h0000_0000;
  localparam logic [31:0] IO_END_RST       = 32'h4000_0000;
  localparam logic [31:0] HEAP_LIMIT_RST   = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OP_CHECK    = 2'd0,
    OP_POISON   = 2'd1,
    OP_UNPOISON = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHECK_ENABLE = 3'd0,
    CFG_SHADOW_START = 3'd1,
    CFG_SHADOW_END   = 3'd2,
    CFG_IO_START     = 3'd3,
    CFG_IO_END       = 3'd4,
    CFG_HEAP_LIMIT   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic load;      // take the input word
    logic scan;      // evaluate one shadow byte of a check
    logic fill;      // write one granule of a range
    logic rem;       // write the partial remainder of an unpoison
    logic clear;     // clearing pass after reset
    logic res_zero;  // finish with an all-zero result
    logic move;      // result stage to output register
  } cmd_t;

  typedef struct packed {
    op_e  acc_op;
    logic acc_span_zero;
    logic acc_rem_nz;
    logic scan_done;
    logic fill_last;
    logic rem_pend;
    logic clr_last;
  } sts_t;

  // granule lies inside the store
  function automatic logic in_store(input logic [GIDX_W-1:0] g);
    return 64'(g) < 64'(STORE_DEPTH);
  endfunction

endpackage

// File: rtl/smac_ram.sv
// ----------------------------------------------------------------------------
// smac_ram
// generic simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module smac_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/smac_dp.sv
// ----------------------------------------------------------------------------
// smac_dp
// datapath: configuration registers, granule walker, shadow store,
// check evaluation, result stage and output register
// ----------------------------------------------------------------------------
module smac_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  smac_pkg::cmd_t                        cmd_i,
  output smac_pkg::sts_t                        sts_o,
  input  logic                                  cfg_we_i,
  input  logic [smac_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [smac_pkg::CFG_DATA_W-1:0]       cfg_wdata_i,
  input  logic [1:0]                            op_i,
  input  logic [smac_pkg::ADDR_W-1:0]           access_address_i,
  input  logic [smac_pkg::LEN_W-1:0]            length_i,
  input  logic [smac_pkg::FILL_W-1:0]           fill_value_i,
  input  logic                                  access_wr_i,
  output logic                                  fault_o,
  output logic [smac_pkg::ADDR_W-1:0]           fault_address_o,
  output logic [smac_pkg::SHADOW_W-1:0]         fault_shadow_o,
  output logic                                  fault_wr_o
);

  localparam int unsigned GS  = smac_pkg::GRANULE_SHIFT;
  localparam int unsigned AW  = smac_pkg::ADDR_W;
  localparam int unsigned GW  = smac_pkg::GIDX_W;
  localparam int unsigned LW  = smac_pkg::CLEN_W;
  localparam int unsigned SIB = smac_pkg::SHADOW_INDEX_BITS;
  localparam int unsigned SW  = smac_pkg::SHADOW_W;

  // configuration
  logic          cen_q;
  logic [AW-1:0] srs_q, sre_q, ios_q, ioe_q, heap_q;

  // item registers
  logic [AW-1:0] addr_q;
  logic [LW-1:0] len_q;
  logic [AW:0]   end_q;
  logic [GW-1:0] cur_q;
  logic [SW-1:0] wval_q;
  logic          wr_q, unp_q, remnz_q, lenz_q;
  logic          rd_ok_q;
  logic [SIB-1:0] clr_q;

  // result stage and output register
  logic          res_fault_q, out_fault_q;
  logic [AW-1:0] res_addr_q, out_addr_q;
  logic [SW-1:0] res_shadow_q, out_shadow_q;
  logic          res_wr_q, out_wr_q;

  // input side
  smac_pkg::op_e acc_op;
  logic [GW-1:0] gin;
  logic [LW-1:0] len_c, whole, span;
  logic [AW:0]   end_sum;

  assign acc_op  = smac_pkg::op_e'(op_i);
  assign gin     = GW'(access_address_i >> GS);
  assign len_c   = (33'(length_i) > 33'(smac_pkg::MAX_LENGTH)) ? LW'(smac_pkg::MAX_LENGTH)
                                                              : LW'(length_i);
  assign whole   = len_c & ~LW'((1 << GS) - 1);
  assign span    = (acc_op == smac_pkg::OP_UNPOISON) ? whole : len_c;
  assign end_sum = {1'b0, access_address_i} + (AW+1)'(span) - (AW+1)'(1);

  // walker
  logic [GW-1:0] cur_nx;
  logic [GW-1:0] end_g;
  logic          is_last;
  assign cur_nx  = cur_q + GW'(1);
  assign end_g   = end_q[AW:GS];
  assign is_last = (cur_q == end_g);

  // shadow store
  logic            ram_we;
  logic [SIB-1:0]  ram_waddr, ram_raddr;
  logic [SW-1:0]   ram_wdata, ram_rdata;
  logic [GW-1:0]   rem_g;

  assign rem_g = GW'(({1'b0, addr_q} + (AW+1)'(len_q)) >> GS);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = SIB'(cur_q);
    ram_wdata = wval_q;
    if (cmd_i.clear) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else if (cmd_i.fill) begin
      ram_we    = smac_pkg::in_store(cur_q);
    end else if (cmd_i.rem) begin
      ram_we    = smac_pkg::in_store(rem_g);
      ram_waddr = SIB'(rem_g);
      ram_wdata = SW'(len_q[GS-1:0]);
    end
  end

  assign ram_raddr = cmd_i.load ? SIB'(gin) : SIB'(cur_nx);

  smac_ram #(
    .WIDTH (SW),
    .DEPTH (smac_pkg::STORE_DEPTH)
  ) u_smac_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // check evaluation on the byte read last cycle
  logic [SW-1:0] shadow;
  logic [7:0]    off8;
  logic          exempt, pass_early, ok_last, scan_fault, scan_done;

  assign shadow     = rd_ok_q ? ram_rdata : '0;
  assign off8       = 8'(end_q[GS-1:0]);
  assign exempt     = ((srs_q <= addr_q) && (end_q < {1'b0, sre_q})) ||
                      ((ios_q <= addr_q) && (end_q < {1'b0, ioe_q})) ||
                      ({1'b0, heap_q} <= end_q);
  assign pass_early = !cen_q || lenz_q || exempt;
  assign ok_last    = is_last && ($signed(off8) < $signed(shadow));
  assign scan_fault = !pass_early && (shadow != '0) && !ok_last;
  assign scan_done  = pass_early || (shadow != '0) || is_last;

  always_comb begin
    sts_o               = '0;
    sts_o.acc_op        = acc_op;
    sts_o.acc_span_zero = (span == '0);
    sts_o.acc_rem_nz    = (len_c[GS-1:0] != '0);
    sts_o.scan_done     = scan_done;
    sts_o.fill_last     = is_last;
    sts_o.rem_pend      = unp_q && remnz_q;
    sts_o.clr_last      = &clr_q;
  end

  // configuration and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cen_q   <= smac_pkg::CHECK_ENABLE_RST;
      srs_q   <= smac_pkg::SHADOW_START_RST;
      sre_q   <= smac_pkg::SHADOW_END_RST;
      ios_q   <= smac_pkg::IO_START_RST;
      ioe_q   <= smac_pkg::IO_END_RST;
      heap_q  <= smac_pkg::HEAP_LIMIT_RST;
      rd_ok_q <= 1'b0;
      clr_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (smac_pkg::cfg_idx_e'(cfg_index_i))
          smac_pkg::CFG_CHECK_ENABLE: cen_q  <= cfg_wdata_i[0];
          smac_pkg::CFG_SHADOW_START: srs_q  <= cfg_wdata_i;
          smac_pkg::CFG_SHADOW_END:   sre_q  <= cfg_wdata_i;
          smac_pkg::CFG_IO_START:     ios_q  <= cfg_wdata_i;
          smac_pkg::CFG_IO_END:       ioe_q  <= cfg_wdata_i;
          smac_pkg::CFG_HEAP_LIMIT:   heap_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      rd_ok_q <= cmd_i.load ? smac_pkg::in_store(gin) : smac_pkg::in_store(cur_nx);
      if (cmd_i.clear) begin
        clr_q <= clr_q + SIB'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q  <= access_address_i;
      len_q   <= len_c;
      end_q   <= end_sum;
      cur_q   <= gin;
      wval_q  <= (acc_op == smac_pkg::OP_POISON) ? fill_value_i : '0;
      wr_q    <= access_wr_i;
      unp_q   <= (acc_op == smac_pkg::OP_UNPOISON);
      remnz_q <= (len_c[GS-1:0] != '0);
      lenz_q  <= (len_c == '0);
    end else if ((cmd_i.scan && !scan_done) || cmd_i.fill) begin
      cur_q   <= cur_nx;
    end

    if (cmd_i.res_zero) begin
      res_fault_q  <= 1'b0;
      res_addr_q   <= '0;
      res_shadow_q <= '0;
      res_wr_q     <= 1'b0;
    end else if (cmd_i.scan && scan_done) begin
      res_fault_q  <= scan_fault;
      res_addr_q   <= scan_fault ? AW'({cur_q, {GS{1'b0}}}) : '0;
      res_shadow_q <= scan_fault ? shadow : '0;
      res_wr_q     <= scan_fault && wr_q;
    end

    if (cmd_i.move) begin
      out_fault_q  <= res_fault_q;
      out_addr_q   <= res_addr_q;
      out_shadow_q <= res_shadow_q;
      out_wr_q     <= res_wr_q;
    end
  end

  assign fault_o         = out_fault_q;
  assign fault_address_o = out_addr_q;
  assign fault_shadow_o  = out_shadow_q;
  assign fault_wr_o      = out_wr_q;

endmodule

// File: rtl/smac_ctrl.sv
// ----------------------------------------------------------------------------
// smac_ctrl
// controller: clearing pass, operation sequencing and result handshake
// ----------------------------------------------------------------------------
module smac_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  smac_pkg::sts_t sts_i,
  output smac_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FILL,
    ST_REM
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   res_pend_q, res_pend_d;
  logic   move, finish, in_ready;

  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    move     = res_pend_q && (!out_valid_q || out_ready_i);
    in_ready = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = !res_pend_q || move;
        if (in_valid_i && in_ready) begin
          cmd_o.load = 1'b1;
          case (sts_i.acc_op)
            smac_pkg::OP_CHECK: state_d = ST_SCAN;
            smac_pkg::OP_POISON: begin
              if (sts_i.acc_span_zero) begin
                cmd_o.res_zero = 1'b1;
              end else begin
                state_d = ST_FILL;
              end
            end
            smac_pkg::OP_UNPOISON: begin
              if (!sts_i.acc_span_zero) begin
                state_d = ST_FILL;
              end else if (sts_i.acc_rem_nz) begin
                state_d = ST_REM;
              end else begin
                cmd_o.res_zero = 1'b1;
              end
            end
            default: cmd_o.res_zero = 1'b1;
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_FILL: begin
        cmd_o.fill = 1'b1;
        if (sts_i.fill_last) begin
          if (sts_i.rem_pend) begin
            state_d = ST_REM;
          end else begin
            cmd_o.res_zero = 1'b1;
            state_d        = ST_IDLE;
          end
        end
      end
      ST_REM: begin
        cmd_o.rem      = 1'b1;
        cmd_o.res_zero = 1'b1;
        state_d        = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    cmd_o.move  = move;
    finish      = cmd_o.res_zero || (cmd_o.scan && sts_i.scan_done);
    res_pend_d  = (res_pend_q && !move) || finish;
    out_valid_d = (out_valid_q && !out_ready_i) || move;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
      res_pend_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      res_pend_q  <= res_pend_d;
    end
  end

  assign in_ready_o  = in_ready;
  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/shadow_memory_access_checker.sv
// ----------------------------------------------------------------------------
// shadow_memory_access_checker
// checks accesses against a byte-per-granule shadow store and poisons or
// unpoisons ranges of it
// ----------------------------------------------------------------------------
// rate: one granule scanned or filled per cycle after a word is taken
//   (unpoison adds a step for a partial remainder)
// result: the step that finishes the word (last scan, fill or remainder
//   step, or the taking cycle itself) loads the result stage, which moves
//   on to the output register once that is free
// reset: shadow store cleared by a pass over its 2^16 entries, one a cycle,
//   during which no word is taken; configuration writes are taken throughout
module shadow_memory_access_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [smac_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [smac_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // request channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      op_i,
  input  logic [smac_pkg::ADDR_W-1:0]     access_address_i,
  input  logic [smac_pkg::LEN_W-1:0]      length_i,
  input  logic [smac_pkg::FILL_W-1:0]     fill_value_i,
  input  logic                            access_wr_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            fault_o,
  output logic [smac_pkg::ADDR_W-1:0]     fault_address_o,
  output logic [smac_pkg::SHADOW_W-1:0]   fault_shadow_o,
  output logic                            fault_wr_o
);

  // commands down to the datapath, status back up
  smac_pkg::cmd_t cmd;
  smac_pkg::sts_t sts;

  // controller: clearing pass, per-operation sequencing, and the valid bits
  // of the result stage and output register, so a finished word can wait
  // downstream while the next request is already taken
  smac_ctrl u_smac_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: the granule walker issues the first shadow read while the
  // word is taken, then evaluates one byte a cycle with the next read in
  // flight; fills write one granule a cycle through the same store
  smac_dp u_smac_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .op_i             (op_i),
    .access_address_i (access_address_i),
    .length_i         (length_i),
    .fill_value_i     (fill_value_i),
    .access_wr_i      (access_wr_i),
    .fault_o          (fault_o),
    .fault_address_o  (fault_address_o),
    .fault_shadow_o   (fault_shadow_o),
    .fault_wr_o       (fault_wr_o)
  );

endmodule

// File: rtl/smac_chk.sv
// ----------------------------------------------------------------------------
// smac_chk
// port-level assertions for the shadow memory access checker
// ----------------------------------------------------------------------------
module smac_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic                          fault_o,
  input logic [smac_pkg::ADDR_W-1:0]   fault_address_o,
  input logic [smac_pkg::SHADOW_W-1:0] fault_shadow_o,
  input logic                          fault_wr_o
);

  // a stalled result word stays and holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(fault_o) &&
    $stable(fault_address_o) && $stable(fault_shadow_o) && $stable(fault_wr_o))
    else $error("stalled result word changed");

  // a passing word carries no fault detail
  a_pass_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !fault_o |->
    fault_address_o == '0 && fault_shadow_o == '0 && !fault_wr_o)
    else $error("passing word with fault detail");

  // a fault names a granule base and a nonzero shadow byte
  a_fault_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fault_o |->
    fault_shadow_o != '0 && fault_address_o[smac_pkg::GRANULE_SHIFT-1:0] == '0)
    else $error("fault word malformed");

  // no request taken and no result shown as reset is released and the clearing pass starts
  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_ready_o && !out_valid_o)
    else $error("request taken during clearing pass");

endmodule

bind shadow_memory_access_checker smac_chk u_smac_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .fault_o         (fault_o),
  .fault_address_o (fault_address_o),
  .fault_shadow_o  (fault_shadow_o),
  .fault_wr_o      (fault_wr_o)
);

// File: dv/smac_tb_pkg.sv
// ----------------------------------------------------------------------------
// smac_tb_pkg
// result word type and a fault tracker that mirrors the shadow store and the
// configuration of the checker, works out the verdict of every request word
// and compares the result words against those verdicts in order
// ----------------------------------------------------------------------------
package smac_tb_pkg;

  import smac_pkg::*;

  localparam logic [63:0] GRAN_MASK = (64'd1 << GRANULE_SHIFT) - 64'd1;

  typedef struct packed {
    logic                fault;
    logic [ADDR_W-1:0]   address;
    logic [SHADOW_W-1:0] shadow;
    logic                wr;
  } verdict_t;

  class fault_tracker;

    logic [SHADOW_W-1:0] shadow_mirror [STORE_DEPTH];
    logic                check_on;
    logic [31:0]         shadow_lo;
    logic [31:0]         shadow_hi;
    logic [31:0]         io_lo;
    logic [31:0]         io_hi;
    logic [31:0]         heap_top;
    verdict_t            verdicts_due [$];
    int unsigned         mismatches;

    function new();
      foreach (shadow_mirror[i]) shadow_mirror[i] = '0;
      check_on   = CHECK_ENABLE_RST;
      shadow_lo  = SHADOW_START_RST;
      shadow_hi  = SHADOW_END_RST;
      io_lo      = IO_START_RST;
      io_hi      = IO_END_RST;
      heap_top   = HEAP_LIMIT_RST;
      mismatches = 0;
    endfunction

    function void set_register(cfg_idx_e idx, logic [31:0] value);
      case (idx)
        CFG_CHECK_ENABLE: check_on  = value[0];
        CFG_SHADOW_START: shadow_lo = value;
        CFG_SHADOW_END:   shadow_hi = value;
        CFG_IO_START:     io_lo     = value;
        CFG_IO_END:       io_hi     = value;
        CFG_HEAP_LIMIT:   heap_top  = value;
        default: ;
      endcase
    endfunction

    // granules past the store read as zero and drop writes
    function logic [SHADOW_W-1:0] read_granule(logic [63:0] g);
      if (g < 64'(STORE_DEPTH)) begin
        return shadow_mirror[g[SHADOW_INDEX_BITS-1:0]];
      end
      return '0;
    endfunction

    function void write_granule(logic [63:0] g, logic [SHADOW_W-1:0] v);
      if (g < 64'(STORE_DEPTH)) begin
        shadow_mirror[g[SHADOW_INDEX_BITS-1:0]] = v;
      end
    endfunction

    function void mark_range(logic [63:0] base, logic [63:0] len, logic [SHADOW_W-1:0] v);
      logic [63:0] g;
      logic [63:0] last_g;
      if (len == 0) return;
      last_g = (base + len - 64'd1) >> GRANULE_SHIFT;
      for (g = base >> GRANULE_SHIFT; g <= last_g; g++) write_granule(g, v);
    endfunction

    function void note_request(op_e op, logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len_in,
                               logic [FILL_W-1:0] fill, logic wr);
      logic [63:0]         a;
      logic [63:0]         len;
      logic [63:0]         last_b;
      logic [63:0]         last_g;
      logic [63:0]         g;
      logic [SHADOW_W-1:0] s;
      byte                 s_signed;
      logic                found;
      logic                exempt;
      verdict_t            v;
      v   = '0;
      a   = 64'(addr);
      len = 64'(len_in);
      if (len > 64'(MAX_LENGTH)) len = 64'(MAX_LENGTH);
      case (op)
        OP_POISON: mark_range(a, len, fill);
        OP_UNPOISON: begin
          mark_range(a, len & ~GRAN_MASK, '0);
          if ((len & GRAN_MASK) != 0) begin
            write_granule((a + len) >> GRANULE_SHIFT, SHADOW_W'(len & GRAN_MASK));
          end
        end
        OP_CHECK: begin
          if (check_on && len != 0) begin
            last_b = a + len - 64'd1;
            exempt = (64'(shadow_lo) <= a && last_b < 64'(shadow_hi)) ||
                     (64'(io_lo) <= a && last_b < 64'(io_hi)) ||
                     (64'(heap_top) <= last_b);
            if (!exempt) begin
              last_g = last_b >> GRANULE_SHIFT;
              found  = 1'b0;
              for (g = a >> GRANULE_SHIFT; g <= last_g && !found; g++) begin
                s = read_granule(g);
                if (s != 0) begin
                  found    = 1'b1;
                  s_signed = s;
                  // a partial granule at the end still covers the last byte
                  if (!(g == last_g && int'(last_b & GRAN_MASK) < int'(s_signed))) begin
                    v.fault   = 1'b1;
                    v.address = ADDR_W'(g << GRANULE_SHIFT);
                    v.shadow  = s;
                    v.wr      = wr;
                  end
                end
              end
            end
          end
        end
        default: ;
      endcase
      verdicts_due.push_back(v);
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      if (verdicts_due.size() == 0) begin
        $error("unexpected result word: fault %0d, fault_address %h", got.fault, got.address);
        mismatches++;
        return;
      end
      want = verdicts_due.pop_front();
      if (got.fault !== want.fault) begin
        $error("fault: expected %0d, got %0d", want.fault, got.fault);
        mismatches++;
      end
      if (got.address !== want.address) begin
        $error("fault_address: expected %h, got %h", want.address, got.address);
        mismatches++;
      end
      if (got.shadow !== want.shadow) begin
        $error("fault_shadow: expected %h, got %h", want.shadow, got.shadow);
        mismatches++;
      end
      if (got.wr !== want.wr) begin
        $error("fault_wr: expected %0d, got %0d", want.wr, got.wr);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return verdicts_due.size();
    endfunction

  endclass

endpackage

// File: dv/shadow_memory_access_checker_tb.sv
// ----------------------------------------------------------------------------
// shadow_memory_access_checker_tb
// drives check, poison and unpoison words into the checker under several
// register configurations, with random gaps and stalls on both channels, and
// compares every result word against a mirror of the shadow store
// ----------------------------------------------------------------------------
module shadow_memory_access_checker_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import smac_pkg::*;
  import smac_tb_pkg::*;

  // cycles with no word moving on either channel before giving up; covers the
  // clearing pass after reset and the longest scan several times over
  localparam int unsigned WATCHDOG_LIMIT = 300000;
  // long receiver hold-off so the block backs up and stalls its input
  localparam int unsigned HOLD_CYCLES    = 600;
  localparam int unsigned PHASE_WORDS    = 335;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [1:0]            op_i;
  logic [ADDR_W-1:0]     access_address_i;
  logic [LEN_W-1:0]      length_i;
  logic [FILL_W-1:0]     fill_value_i;
  logic                  access_wr_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic                  fault_o;
  logic [ADDR_W-1:0]     fault_address_o;
  logic [SHADOW_W-1:0]   fault_shadow_o;
  logic                  fault_wr_o;

  fault_tracker tracker;
  int unsigned  n_sent;
  int unsigned  n_recv;
  int unsigned  quiet_cycles;
  bit           hold_req;

  shadow_memory_access_checker u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .op_i             (op_i),
    .access_address_i (access_address_i),
    .length_i         (length_i),
    .fill_value_i     (fill_value_i),
    .access_wr_i      (access_wr_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .fault_o          (fault_o),
    .fault_address_o  (fault_address_o),
    .fault_shadow_o   (fault_shadow_o),
    .fault_wr_o       (fault_wr_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // driving tasks
  // ---------------------------------------------------------------------------

  // one word on the request channel; handshake is looked at on the falling
  // edge so the rising edge after it is the one that takes the word
  task automatic send_word(op_e op, logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len,
                           logic [FILL_W-1:0] fill, logic wr);
    int unsigned gap;
    // every so often a run of back-to-back words with no gaps at all
    gap = ((n_sent % 150) < 40) ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    op_i             <= op;
    access_address_i <= addr;
    length_i         <= len;
    fill_value_i     <= fill;
    access_wr_i      <= wr;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    tracker.note_request(op, addr, len, fill, wr);
    n_sent++;
  endtask

  // drop valid and wait until every result word is back
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tracker.set_register(idx, value);
  endtask

  // registers only change with the block idle
  task automatic apply_settings(logic en, logic [31:0] sh_lo, logic [31:0] sh_hi,
                                logic [31:0] io_lo, logic [31:0] io_hi, logic [31:0] heap);
    settle();
    write_register(CFG_CHECK_ENABLE, 32'(en));
    write_register(CFG_SHADOW_START, sh_lo);
    write_register(CFG_SHADOW_END, sh_hi);
    write_register(CFG_IO_START, io_lo);
    write_register(CFG_IO_END, io_hi);
    write_register(CFG_HEAP_LIMIT, heap);
  endtask

  // an object the way an allocator lays it out: poisoned redzones around it,
  // the object itself unpoisoned (partial tail granule included), then
  // accesses near its edges, and now and then a free followed by a use
  task automatic object_sequence();
    logic [ADDR_W-1:0] base;
    int unsigned       size;
    int unsigned       rz;
    int                off;
    logic [LEN_W-1:0]  len;
    base = ADDR_W'($urandom_range(8, 12'h7E0)) << GRANULE_SHIFT;
    size = ($urandom_range(0, 9) == 0) ? $urandom_range(65, 400) : $urandom_range(1, 64);
    rz   = $urandom_range(1, 4) << GRANULE_SHIFT;
    send_word(OP_POISON, base - rz, LEN_W'(size + 2 * rz), 8'($urandom_range(241, 254)),
              1'($urandom));
    send_word(OP_UNPOISON, base, LEN_W'(size), 8'($urandom), 1'($urandom));
    repeat ($urandom_range(2, 6)) begin
      off = int'($urandom_range(0, size + 2 * rz)) - int'(rz);
      len = $urandom_range(0, 1) ? (LEN_W'(1) << $urandom_range(0, 4))
                                 : LEN_W'($urandom_range(1, 24));
      send_word(OP_CHECK, base + ADDR_W'(off), len, 8'($urandom), 1'($urandom));
    end
    if ($urandom_range(0, 4) == 0) begin
      send_word(OP_POISON, base, LEN_W'(size), 8'hFD, 1'($urandom));
      send_word(OP_CHECK, base + $urandom_range(0, size - 1), LEN_W'($urandom_range(1, 8)),
                8'($urandom), 1'($urandom));
    end
  endtask

  // a word with loosely shaped random fields; long lengths stay rare
  task automatic noise_word();
    op_e               op;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    int unsigned       pick;
    pick = $urandom_range(0, 9);
    op   = (pick < 4) ? OP_CHECK : (pick < 6) ? OP_POISON : (pick < 9) ? OP_UNPOISON : OP_NONE;
    pick = $urandom_range(0, 9);
    if (pick < 5) begin
      addr = $urandom_range(0, 16'h3FFF);
    end else if (pick < 7) begin
      // straddles the top of the store
      addr = 32'h0007_FF00 + $urandom_range(0, 16'h200);
    end else begin
      addr = $urandom;
    end
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      len = LEN_W'($urandom_range(0, 32));
    end else if (pick < 98) begin
      len = LEN_W'($urandom_range(0, 2048));
    end else begin
      len = LEN_W'($urandom_range(0, 17'h1FFFF));
    end
    send_word(op, addr, len, 8'($urandom), 1'($urandom));
  endtask

  task automatic random_phase(bit hold_mid, bit pause_mid);
    int unsigned start;
    start = n_sent;
    while (n_sent - start < PHASE_WORDS) begin
      if (hold_mid && n_sent - start >= PHASE_WORDS / 2) begin
        hold_req = 1'b1;
        hold_mid = 1'b0;
      end
      if (pause_mid && n_sent - start >= PHASE_WORDS / 3) begin
        settle();
        pause_mid = 1'b0;
      end
      if ($urandom_range(0, 99) < 55) begin
        object_sequence();
      end else begin
        noise_word();
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls, runs without stalls, and one long hold-off
  // whenever the stimulus asks for it
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    verdict_t    seen;
    int unsigned stall;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = ((n_recv % 170) < 50) ? 0 : $urandom_range(0, 18);
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = HOLD_CYCLES;
      end
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(negedge clk_i); while (!out_valid_o);
      seen.fault   = fault_o;
      seen.address = fault_address_o;
      seen.shadow  = fault_shadow_o;
      seen.wr      = fault_wr_o;
      @(posedge clk_i);
      tracker.check_verdict(seen);
      n_recv++;
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: counts cycles in which no word moves on either channel
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    quiet_cycles = 0;
    forever begin
      @(negedge clk_i);
      if (rst_ni !== 1'b1 || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    tracker          = new();
    n_sent           = 0;
    n_recv           = 0;
    hold_req         = 1'b0;
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_index_i      <= CFG_CHECK_ENABLE;
    cfg_wdata_i      <= '0;
    in_valid_i       <= 1'b0;
    op_i             <= OP_CHECK;
    access_address_i <= '0;
    length_i         <= '0;
    fill_value_i     <= '0;
    access_wr_i      <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset register values: checking off, so a check of poisoned memory
    // passes; the first word also waits out the clearing pass
    send_word(OP_POISON, 32'h0000_0100, 17'd32, 8'hFA, 1'b0);
    send_word(OP_CHECK, 32'h0000_0100, 17'd4, 8'h00, 1'b1);
    // unused op code, every field at its top
    send_word(OP_NONE, 32'hFFFF_FFFF, 17'h1FFFF, 8'hFF, 1'b1);

    apply_settings(1'b1, 32'h0000_6000, 32'h0000_7000, 32'h0007_0000, 32'h0007_8000,
                   32'hFFFF_0000);
    // poisoned granule, and one reached from the granule before it
    send_word(OP_CHECK, 32'h0000_0100, 17'd4, 8'h00, 1'b1);
    send_word(OP_CHECK, 32'h0000_00FC, 17'd8, 8'h00, 1'b0);
    // unpoison with a partial tail granule, then touch its edge from both sides
    send_word(OP_UNPOISON, 32'h0000_0100, 17'd13, 8'h00, 1'b0);
    send_word(OP_CHECK, 32'h0000_0108, 17'd5, 8'h00, 1'b0);
    send_word(OP_CHECK, 32'h0000_0108, 17'd6, 8'h00, 1'b1);
    // zero length
    send_word(OP_CHECK, 32'h0000_0100, 17'd0, 8'h00, 1'b0);
    // shadow byte with the sign bit set, and a large positive one at the end
    send_word(OP_POISON, 32'h0000_0200, 17'd8, 8'h80, 1'b0);
    send_word(OP_POISON, 32'h0000_0208, 17'd1, 8'h7F, 1'b0);
    send_word(OP_CHECK, 32'h0000_0208, 17'd8, 8'h00, 1'b0);
    send_word(OP_CHECK, 32'h0000_0200, 17'd16, 8'h00, 1'b1);
    // shadow region: exempt inside, not when the access starts below it
    send_word(OP_POISON, 32'h0000_6000, 17'd16, 8'hFF, 1'b0);
    send_word(OP_CHECK, 32'h0000_6000, 17'd8, 8'h00, 1'b0);
    send_word(OP_CHECK, 32'h0000_5FFC, 17'd8, 8'h00, 1'b1);
    // top of the store: the granule past it reads as zero and drops writes
    send_word(OP_POISON, 32'h0007_FFF8, 17'd16, 8'hF1, 1'b0);
    send_word(OP_CHECK, 32'h0008_0000, 17'd8, 8'h00, 1'b0);
    send_word(OP_CHECK, 32'h0007_FFFC, 17'd8, 8'h00, 1'b1);
    // overlong access running past the address space, exempt by the heap limit
    send_word(OP_CHECK, 32'hFFFF_FFF8, 17'h1FFFF, 8'h00, 1'b1);
    // unaligned unpoison start
    send_word(OP_POISON, 32'h0000_0400, 17'd24, 8'hFC, 1'b0);
    send_word(OP_UNPOISON, 32'h0000_0403, 17'd10, 8'h00, 1'b0);
    send_word(OP_CHECK, 32'h0000_0408, 17'd3, 8'h00, 1'b0);
    // empty range, then the largest range
    send_word(OP_UNPOISON, 32'h0000_0300, 17'd0, 8'h00, 1'b0);
    send_word(OP_UNPOISON, 32'h0000_0000, 17'h10000, 8'h00, 1'b0);

    // random part over several register configurations, extremes included
    random_phase(1'b1, 1'b0);
    apply_settings(1'b1, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF);
    random_phase(1'b0, 1'b1);
    apply_settings(1'b1, 32'h0000_0000, 32'h0000_2000, 32'h0000_3000, 32'h0000_3800,
                   32'h0000_8000);
    random_phase(1'b1, 1'b0);
    apply_settings(1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                   32'h0000_0000);
    random_phase(1'b0, 1'b0);
    apply_settings(1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                   32'hFFFF_FFFF);
    random_phase(1'b0, 1'b0);

    // drain and let the pipeline run dry
    settle();
    repeat (12) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
